@@ hw/rtl/rlf_pkg.sv @@
// ----------------------------------------------------------------------------
// rlf_pkg
// shared types and constants for the ipv4 route lookup and forward block
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 4;
    localparam int TTL_W  = 8;
    localparam int STAT_W = 2;
    localparam int EIDX_W = 4;

    localparam logic             CMD_WRITE    = 1'b0;
    localparam logic             CMD_FORWARD  = 1'b1;
    localparam logic [TTL_W-1:0] TTL_MIN_PASS = 8'd1;

    localparam logic [STAT_W-1:0] STAT_FORWARDED    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TTL_EXCEEDED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNREACHABLE  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_WRITTEN      = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } t_slot;

    typedef struct packed {
        logic clear;
        logic update;
    } t_match_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/ipv4_route_lookup_forward.sv @@
// ----------------------------------------------------------------------------
// ipv4_route_lookup_forward
// route table with longest prefix match lookup and ttl check
//
//   channel  handshake                direction  payload
//   input    i_in_valid/o_in_stall    in         cmd, entry, route, dest, ttl
//   output   o_out_valid/i_out_stall  out        status, hop address, port, ttl
//
// a write item or a ttl-expired lookup goes from idle straight to done; a
// lookup scans the table, reading one table slot per cycle from
// the single read port of the table memory, then drains the read register
// after reset a clearing pass writes every table slot before the
// first item is taken
// a new item is taken while the registered result waits on a stalled output
// ----------------------------------------------------------------------------
module ipv4_route_lookup_forward #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NUM_PORTS     = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [rlf_pkg::EIDX_W-1:0]  i_entry_index,
    input  logic                        i_entry_valid,
    input  logic [rlf_pkg::ADDR_W-1:0]  i_route_dest,
    input  logic [rlf_pkg::ADDR_W-1:0]  i_route_mask,
    input  logic [rlf_pkg::ADDR_W-1:0]  i_route_gateway,
    input  logic [rlf_pkg::PORT_W-1:0]  i_route_port,
    input  logic [rlf_pkg::ADDR_W-1:0]  i_dest_addr,
    input  logic [rlf_pkg::TTL_W-1:0]   i_ttl_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rlf_pkg::STAT_W-1:0]  o_status,
    output logic [rlf_pkg::ADDR_W-1:0]  o_hop_addr,
    output logic [rlf_pkg::PORT_W-1:0]  o_out_port,
    output logic [rlf_pkg::TTL_W-1:0]   o_ttl_out
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [rlf_pkg::PORT_W-1:0] MAX_PORT = rlf_pkg::PORT_W'(NUM_PORTS - 1);

    rlf_pkg::t_state r_state;
    rlf_pkg::t_state n_state;

    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           n_idx;
    logic                       r_cmd;
    logic                       r_ttl_fail;
    logic [rlf_pkg::ADDR_W-1:0] r_addr;
    logic [rlf_pkg::TTL_W-1:0]  r_ttl;

    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [rlf_pkg::STAT_W-1:0]  r_status;
    logic [rlf_pkg::STAT_W-1:0]  n_status;
    logic [rlf_pkg::ADDR_W-1:0]  r_hop_addr;
    logic [rlf_pkg::ADDR_W-1:0]  n_hop_addr;
    logic [rlf_pkg::PORT_W-1:0]  r_out_port;
    logic [rlf_pkg::PORT_W-1:0]  n_out_port;
    logic [rlf_pkg::TTL_W-1:0]   r_ttl_out;
    logic [rlf_pkg::TTL_W-1:0]   n_ttl_out;

    logic                        accept;
    logic                        ttl_fail;
    logic                        in_range;
    logic [rlf_pkg::PORT_W-1:0]  sat_port;
    logic                        out_load;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    rlf_pkg::t_slot              wr_data;
    logic                        rd_en;
    rlf_pkg::t_slot              rd_data;
    logic                        rd_vld;
    rlf_pkg::t_match_ctl         mctl;
    logic                        found;
    logic [rlf_pkg::ADDR_W-1:0]  best_gateway;
    logic [rlf_pkg::PORT_W-1:0]  best_port;

    assign o_in_stall = (r_state != rlf_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign ttl_fail   = (i_ttl_in <= rlf_pkg::TTL_MIN_PASS);
    assign in_range   = (32'(i_entry_index) < TABLE_ENTRIES);
    assign sat_port   = (32'(i_route_port) >= NUM_PORTS) ? MAX_PORT : i_route_port;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rlf_pkg::S_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = rlf_pkg::S_IDLE;
                end
            end
            rlf_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd == rlf_pkg::CMD_FORWARD && !ttl_fail) begin
                        n_state = rlf_pkg::S_SCAN;
                    end else begin
                        n_state = rlf_pkg::S_DONE;
                    end
                end
            end
            rlf_pkg::S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = rlf_pkg::S_DRAIN;
                end
            end
            rlf_pkg::S_DRAIN: begin
                n_state = rlf_pkg::S_DONE;
            end
            rlf_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = rlf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlf_pkg::S_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = '0;
        rd_en        = 1'b0;
        mctl.clear   = 1'b0;
        mctl.update  = rd_vld;
        out_load     = 1'b0;
        n_idx        = r_idx;
        case (r_state)
            rlf_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            rlf_pkg::S_IDLE: begin
                n_idx = '0;
                if (accept && i_cmd == rlf_pkg::CMD_WRITE) begin
                    wr_en           = in_range;
                    wr_addr         = IDX_W'(i_entry_index);
                    wr_data.valid   = i_entry_valid;
                    wr_data.dest    = i_route_dest;
                    wr_data.mask    = i_route_mask;
                    wr_data.gateway = i_route_gateway;
                    wr_data.port    = sat_port;
                end
                mctl.clear = accept;
            end
            rlf_pkg::S_SCAN: begin
                rd_en = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            rlf_pkg::S_DRAIN: begin
                n_idx = '0;
            end
            rlf_pkg::S_DONE: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // result selection
    always_comb begin
        n_status   = rlf_pkg::STAT_WRITTEN;
        n_hop_addr = '0;
        n_out_port = '0;
        n_ttl_out  = '0;
        if (r_cmd == rlf_pkg::CMD_FORWARD) begin
            if (r_ttl_fail) begin
                n_status = rlf_pkg::STAT_TTL_EXCEEDED;
            end else if (!found) begin
                n_status  = rlf_pkg::STAT_UNREACHABLE;
                n_ttl_out = r_ttl - 8'd1;
            end else begin
                n_status   = rlf_pkg::STAT_FORWARDED;
                n_hop_addr = (best_gateway != '0) ? best_gateway : r_addr;
                n_out_port = best_port;
                n_ttl_out  = r_ttl - 8'd1;
            end
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlf_pkg::S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_cmd;
            r_ttl_fail <= ttl_fail;
            r_addr     <= i_dest_addr;
            r_ttl      <= i_ttl_in;
        end
        if (out_load) begin
            r_status   <= n_status;
            r_hop_addr <= n_hop_addr;
            r_out_port <= n_out_port;
            r_ttl_out  <= n_ttl_out;
        end
    end

    rlf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld)
    );

    rlf_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mctl),
        .i_addr    (r_addr),
        .i_slot    (rd_data),
        .o_found   (found),
        .o_gateway (best_gateway),
        .o_port    (best_port)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_hop_addr  = r_hop_addr;
    assign o_out_port  = r_out_port;
    assign o_ttl_out   = r_ttl_out;

endmodule

@@ hw/rtl/rlf_table.sv @@
// ----------------------------------------------------------------------------
// rlf_table
// route table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module rlf_table #(
    parameter int TABLE_ENTRIES = 16,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  rlf_pkg::t_slot     i_wr_data,
    input  logic               i_rd_en,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output rlf_pkg::t_slot     o_rd_data,
    output logic               o_rd_vld
);

    rlf_pkg::t_slot mem [TABLE_ENTRIES];
    rlf_pkg::t_slot r_rd_data;
    logic           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

@@ hw/rtl/rlf_match.sv @@
// ----------------------------------------------------------------------------
// rlf_match
// per-slot prefix compare and best-match tracking over a table scan
// ----------------------------------------------------------------------------
module rlf_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rlf_pkg::t_match_ctl         i_ctl,
    input  logic [rlf_pkg::ADDR_W-1:0]  i_addr,
    input  rlf_pkg::t_slot              i_slot,
    output logic                        o_found,
    output logic [rlf_pkg::ADDR_W-1:0]  o_gateway,
    output logic [rlf_pkg::PORT_W-1:0]  o_port
);

    logic                       r_found;
    logic [rlf_pkg::ADDR_W-1:0] r_mask;
    logic [rlf_pkg::ADDR_W-1:0] r_gateway;
    logic [rlf_pkg::PORT_W-1:0] r_port;
    logic                       hit;
    logic                       take;

    // numerically larger mask wins, equal mask keeps the earlier slot
    always_comb begin
        hit  = i_slot.valid && (((i_addr ^ i_slot.dest) & i_slot.mask) == '0);
        take = i_ctl.update && hit && (!r_found || (r_mask < i_slot.mask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mask    <= i_slot.mask;
            r_gateway <= i_slot.gateway;
            r_port    <= i_slot.port;
        end
    end

    assign o_found   = r_found;
    assign o_gateway = r_gateway;
    assign o_port    = r_port;

endmodule

@@ tb/ipv4_route_lookup_forward_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_lookup_forward_tb
// writes route table entries and runs lookups through the valid/stall
// channels. a shadow route table predicts every result, and each result is
// compared field by field in order. a short directed table covers the ttl
// limits, host and default routes, ties and cleared entries. a long random
// run follows, with idle bursts on both channels and a quiet tail.
// ----------------------------------------------------------------------------
module ipv4_route_lookup_forward_tb;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                       cmd;
        logic [rlf_pkg::EIDX_W-1:0] idx;
        logic                       on;
        logic [rlf_pkg::ADDR_W-1:0] dest;
        logic [rlf_pkg::ADDR_W-1:0] mask;
        logic [rlf_pkg::ADDR_W-1:0] gateway;
        logic [rlf_pkg::PORT_W-1:0] port;
        logic [rlf_pkg::ADDR_W-1:0] addr;
        logic [rlf_pkg::TTL_W-1:0]  ttl;
    } t_route_item;

    typedef struct packed {
        logic [rlf_pkg::STAT_W-1:0] status;
        logic [rlf_pkg::ADDR_W-1:0] hop_addr;
        logic [rlf_pkg::PORT_W-1:0] out_port;
        logic [rlf_pkg::TTL_W-1:0]  ttl_out;
    } t_route_result;

    typedef struct packed {
        logic          known;
        t_route_result r;
    } t_typed_result;

    typedef struct packed {
        t_route_item   it;
        logic          known;
        t_route_result want;
    } t_directed_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_cmd;
    logic [rlf_pkg::EIDX_W-1:0]   i_entry_index;
    logic                         i_entry_valid;
    logic [rlf_pkg::ADDR_W-1:0]   i_route_dest;
    logic [rlf_pkg::ADDR_W-1:0]   i_route_mask;
    logic [rlf_pkg::ADDR_W-1:0]   i_route_gateway;
    logic [rlf_pkg::PORT_W-1:0]   i_route_port;
    logic [rlf_pkg::ADDR_W-1:0]   i_dest_addr;
    logic [rlf_pkg::TTL_W-1:0]    i_ttl_in;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [rlf_pkg::STAT_W-1:0]   o_status;
    logic [rlf_pkg::ADDR_W-1:0]   o_hop_addr;
    logic [rlf_pkg::PORT_W-1:0]   o_out_port;
    logic [rlf_pkg::TTL_W-1:0]    o_ttl_out;

    // shadow route table used for prediction
    logic                         fib_valid   [NUM_SLOTS];
    logic [rlf_pkg::ADDR_W-1:0]   fib_dest    [NUM_SLOTS];
    logic [rlf_pkg::ADDR_W-1:0]   fib_mask    [NUM_SLOTS];
    logic [rlf_pkg::ADDR_W-1:0]   fib_gateway [NUM_SLOTS];
    logic [rlf_pkg::PORT_W-1:0]   fib_port    [NUM_SLOTS];

    // routes as sent, used only to aim random lookups
    logic [rlf_pkg::ADDR_W-1:0]   aim_dest [NUM_SLOTS];
    logic [rlf_pkg::ADDR_W-1:0]   aim_mask [NUM_SLOTS];

    t_route_result       pending_results[$];
    t_typed_result       typed_queue[$];
    t_directed_row       directed_rows[$];
    int                  fail_count = 0;
    logic                calm = 1'b0;

    ipv4_route_lookup_forward DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_entry_valid  (i_entry_valid),
        .i_route_dest   (i_route_dest),
        .i_route_mask   (i_route_mask),
        .i_route_gateway(i_route_gateway),
        .i_route_port   (i_route_port),
        .i_dest_addr    (i_dest_addr),
        .i_ttl_in       (i_ttl_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_hop_addr     (o_hop_addr),
        .o_out_port     (o_out_port),
        .o_ttl_out      (o_ttl_out)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_route_result result_of(input logic [rlf_pkg::STAT_W-1:0] st,
                                                input logic [rlf_pkg::ADDR_W-1:0] hop,
                                                input logic [rlf_pkg::PORT_W-1:0] port,
                                                input logic [rlf_pkg::TTL_W-1:0] ttl);
        t_route_result res;
        res.status   = st;
        res.hop_addr = hop;
        res.out_port = port;
        res.ttl_out  = ttl;
        return res;
    endfunction

    function automatic t_route_item write_item(input logic [rlf_pkg::EIDX_W-1:0] idx,
                                               input logic on,
                                               input logic [rlf_pkg::ADDR_W-1:0] d,
                                               input logic [rlf_pkg::ADDR_W-1:0] m,
                                               input logic [rlf_pkg::ADDR_W-1:0] g,
                                               input logic [rlf_pkg::PORT_W-1:0] p);
        t_route_item it;
        it.cmd     = rlf_pkg::CMD_WRITE;
        it.idx     = idx;
        it.on      = on;
        it.dest    = d;
        it.mask    = m;
        it.gateway = g;
        it.port    = p;
        it.addr    = $urandom;
        it.ttl     = 8'($urandom);
        return it;
    endfunction

    function automatic t_route_item lookup_item(input logic [rlf_pkg::ADDR_W-1:0] a,
                                                input logic [rlf_pkg::TTL_W-1:0] t);
        t_route_item it;
        it.cmd     = rlf_pkg::CMD_FORWARD;
        it.idx     = 4'($urandom);
        it.on      = 1'($urandom);
        it.dest    = $urandom;
        it.mask    = $urandom;
        it.gateway = $urandom;
        it.port    = 4'($urandom);
        it.addr    = a;
        it.ttl     = t;
        return it;
    endfunction

    // updates the shadow table on writes, runs the longest prefix match on lookups
    function automatic t_route_result predict_route(input t_route_item it);
        t_route_result res;
        logic          found;
        int            best;
        res   = '0;
        found = 1'b0;
        best  = 0;
        if (it.cmd == rlf_pkg::CMD_WRITE) begin
            fib_valid[it.idx]   = it.on;
            fib_dest[it.idx]    = it.dest;
            fib_mask[it.idx]    = it.mask;
            fib_gateway[it.idx] = it.gateway;
            fib_port[it.idx]    = it.port;
            res.status          = rlf_pkg::STAT_WRITTEN;
        end else if (it.ttl <= rlf_pkg::TTL_MIN_PASS) begin
            res.status = rlf_pkg::STAT_TTL_EXCEEDED;
        end else begin
            res.ttl_out = it.ttl - 8'd1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (fib_valid[i] && ((it.addr & fib_mask[i]) == (fib_dest[i] & fib_mask[i]))
                        && (!found || fib_mask[best] < fib_mask[i])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                res.status = rlf_pkg::STAT_UNREACHABLE;
            end else begin
                res.status   = rlf_pkg::STAT_FORWARDED;
                res.hop_addr = (fib_gateway[best] != '0) ? fib_gateway[best] : it.addr;
                res.out_port = fib_port[best];
            end
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_item(input t_route_item it, input logic known,
                             input t_route_result want);
        t_typed_result tag;
        tag.known = known;
        tag.r     = want;
        typed_queue.push_back(tag);
        if (it.cmd == rlf_pkg::CMD_WRITE) begin
            aim_dest[it.idx] = it.dest;
            aim_mask[it.idx] = it.mask;
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= it.cmd;
        i_entry_index   <= it.idx;
        i_entry_valid   <= it.on;
        i_route_dest    <= it.dest;
        i_route_mask    <= it.mask;
        i_route_gateway <= it.gateway;
        i_route_port    <= it.port;
        i_dest_addr     <= it.addr;
        i_ttl_in        <= it.ttl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // input acceptance and result checking
    always @(posedge i_clk) begin
        t_route_item   seen;
        t_route_result got;
        t_route_result want;
        t_typed_result tag;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                seen.cmd     = i_cmd;
                seen.idx     = i_entry_index;
                seen.on      = i_entry_valid;
                seen.dest    = i_route_dest;
                seen.mask    = i_route_mask;
                seen.gateway = i_route_gateway;
                seen.port    = i_route_port;
                seen.addr    = i_dest_addr;
                seen.ttl     = i_ttl_in;
                want         = predict_route(seen);
                tag          = typed_queue.pop_front();
                if (tag.known) begin
                    want = tag.r;
                end
                pending_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = result_of(o_status, o_hop_addr, o_out_port, o_ttl_out);
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: status %0d hop %h port %0d ttl %0d",
                                           got.status, got.hop_addr, got.out_port, got.ttl_out));
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.hop_addr !== want.hop_addr
                            || got.out_port !== want.out_port || got.ttl_out !== want.ttl_out) begin
                        note_failure($sformatf({"mismatch: expected status %0d hop %h port %0d ",
                                                "ttl %0d, got status %0d hop %h port %0d ttl %0d"},
                                               want.status, want.hop_addr, want.out_port,
                                               want.ttl_out, got.status, got.hop_addr,
                                               got.out_port, got.ttl_out));
                    end
                end
            end
        end
    end

    // receiver stalls
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_route_item                it;
        t_route_result              wrote;
        logic [rlf_pkg::ADDR_W-1:0] m;
        logic [rlf_pkg::ADDR_W-1:0] a;
        logic [rlf_pkg::TTL_W-1:0]  t;
        int                         j;
        int                         len;
        wrote = result_of(rlf_pkg::STAT_WRITTEN, '0, '0, '0);
        for (int s = 0; s < NUM_SLOTS; s++) begin
            fib_valid[s]   = 1'b0;
            fib_dest[s]    = '0;
            fib_mask[s]    = '0;
            fib_gateway[s] = '0;
            fib_port[s]    = '0;
            aim_dest[s]    = '0;
            aim_mask[s]    = '0;
        end
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_cmd           <= rlf_pkg::CMD_WRITE;
        i_entry_index   <= '0;
        i_entry_valid   <= 1'b0;
        i_route_dest    <= '0;
        i_route_mask    <= '0;
        i_route_gateway <= '0;
        i_route_port    <= '0;
        i_dest_addr     <= '0;
        i_ttl_in        <= '0;

        // empty table, ttl limits
        directed_rows.push_back('{lookup_item(32'h0000_0000, 8'd64), 1'b1,
                                  result_of(rlf_pkg::STAT_UNREACHABLE, '0, '0, 8'd63)});
        directed_rows.push_back('{lookup_item(32'hFFFF_FFFF, 8'd0), 1'b1,
                                  result_of(rlf_pkg::STAT_TTL_EXCEEDED, '0, '0, '0)});
        directed_rows.push_back('{lookup_item(32'h1234_5678, 8'd1), 1'b1,
                                  result_of(rlf_pkg::STAT_TTL_EXCEEDED, '0, '0, '0)});
        directed_rows.push_back('{lookup_item(32'hFFFF_FFFF, 8'd2), 1'b1,
                                  result_of(rlf_pkg::STAT_UNREACHABLE, '0, '0, 8'd1)});
        // default, host, /8, and two equal /16 routes
        directed_rows.push_back('{write_item(4'd0, 1'b1, 32'h0, 32'h0, 32'h0A00_0001, 4'd1),
                                  1'b1, wrote});
        directed_rows.push_back('{write_item(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                             4'd15), 1'b1, wrote});
        directed_rows.push_back('{write_item(4'd3, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0,
                                             4'd3), 1'b1, wrote});
        directed_rows.push_back('{write_item(4'd2, 1'b1, 32'h0A01_0000, 32'hFFFF_0000,
                                             32'hC0A8_0001, 4'd2), 1'b1, wrote});
        directed_rows.push_back('{write_item(4'd5, 1'b1, 32'h0A01_FFFF, 32'hFFFF_0000,
                                             32'hFFFF_FFFF, 4'd5), 1'b1, wrote});
        directed_rows.push_back('{write_item(4'd9, 1'b0, 32'h0B00_0000, 32'hFF00_0000,
                                             32'h0101_0101, 4'd9), 1'b1, wrote});
        directed_rows.push_back('{lookup_item(32'hFFFF_FFFF, 8'd255), 1'b1,
                                  result_of(rlf_pkg::STAT_FORWARDED, 32'hFFFF_FFFF, 4'd15,
                                            8'd254)});
        directed_rows.push_back('{lookup_item(32'h0A01_0203, 8'd64), 1'b0, '0});
        directed_rows.push_back('{lookup_item(32'h0A02_0304, 8'd64), 1'b0, '0});
        directed_rows.push_back('{lookup_item(32'h0B00_0001, 8'd2), 1'b0, '0});
        directed_rows.push_back('{lookup_item(32'h0000_0000, 8'd2), 1'b0, '0});
        // clear the tie winner, then the other /16 takes over
        directed_rows.push_back('{write_item(4'd2, 1'b0, 32'h0A01_0000, 32'hFFFF_0000, 32'h0,
                                             4'd2), 1'b1, wrote});
        directed_rows.push_back('{lookup_item(32'h0A01_0203, 8'd100), 1'b0, '0});
        // non-contiguous mask loses to the numerically larger /8
        directed_rows.push_back('{write_item(4'd7, 1'b1, 32'h00AB_00CD, 32'h00FF_00FF, 32'h0,
                                             4'd7), 1'b1, wrote});
        directed_rows.push_back('{lookup_item(32'h0AAB_01CD, 8'd3), 1'b0, '0});
        directed_rows.push_back('{write_item(4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 4'd0), 1'b1, wrote});
        directed_rows.push_back('{lookup_item(32'h0102_0304, 8'd2), 1'b0, '0});
        directed_rows.push_back('{lookup_item(32'h0A00_0000, 8'd3), 1'b0, '0});
        directed_rows.push_back('{write_item(4'd15, 1'b1, 32'h0, 32'h0, 32'h0, 4'd0), 1'b1, wrote});
        directed_rows.push_back('{lookup_item(32'hC0A8_0101, 8'd255), 1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].it, directed_rows[r].known, directed_rows[r].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 800 && n < 950) || (n >= RANDOM_ITEMS * 17 / 20);
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    len = $urandom_range(0, rlf_pkg::ADDR_W);
                    m   = {rlf_pkg::ADDR_W{1'b1}} << (rlf_pkg::ADDR_W - len);
                end else begin
                    m = $urandom;
                end
                a  = ($urandom_range(0, 2) == 0) ? 32'h0 : 32'($urandom);
                it = write_item(4'($urandom_range(0, NUM_SLOTS - 1)), $urandom_range(0, 7) != 0,
                                $urandom, m, a, 4'($urandom_range(0, 15)));
            end else begin
                j = $urandom_range(0, NUM_SLOTS - 1);
                if ($urandom_range(0, 9) < 7) begin
                    a = (aim_dest[j] & aim_mask[j]) | (32'($urandom) & ~aim_mask[j]);
                end else begin
                    a = $urandom;
                end
                case ($urandom_range(0, 7))
                    0: t = 8'd0;
                    1: t = 8'd1;
                    2: t = 8'd2;
                    3: t = 8'd255;
                    default: t = 8'($urandom_range(0, 255));
                endcase
                it = lookup_item(a, t);
            end
            send_item(it, 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ipv4_route_lookup_forward_tb passed");
        end else begin
            $display("ipv4_route_lookup_forward_tb failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("ipv4_route_lookup_forward_tb failed");
        $finish;
    end

endmodule
